/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the hash table block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHT_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication, disabled while reset is held.
`define CHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

/* sv/cht_pkg.sv */
// Package of the chained hash table: codes, widths, defaults, FSM and
// control types. No dependencies.
`default_nettype none

package cht_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF   = 256;

    localparam int KEY_W   = 32;
    localparam int CFG_W   = 7;
    localparam int REM_W   = CFG_W + 1;
    localparam int DIV_STEPS = KEY_W;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int REQ_W   = 2;
    localparam int ST_W    = 2;

    localparam logic [CFG_W-1:0] TSIZE_RESET = CFG_W'(64);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_DISP,
        S_INS,
        S_WALK,
        S_CMP,
        S_DEL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic rd_free;
        logic ins;
        logic adv;
        logic hit;
        logic free_node;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic             div_done;
        logic [REQ_W-1:0] req;
        logic             cur_nil;
        logic             key_match;
        logic             slot_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/cht_if.sv */
// Request and response channel interfaces of the chained hash table.
// Depends on cht_pkg for field widths.
`default_nettype none

interface cht_req_if;
    logic                             valid;
    logic                             ready;
    logic [cht_pkg::REQ_W-1:0]        req_type;
    logic signed [cht_pkg::KEY_W-1:0] key;
    logic signed [cht_pkg::KEY_W-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface cht_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [cht_pkg::ST_W-1:0]         status;
    logic signed [cht_pkg::KEY_W-1:0] found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

`default_nettype wire

/* sv/cht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/cht_ctrl.sv */
// Controller FSM of the chained hash table: sequences the modulo, the head
// read, the chain walk and the result hand-off. Depends on cht_pkg.
`default_nettype none

module cht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cht_pkg::t_sts i_sts,
    output cht_pkg::t_cmd      o_cmd
);

    cht_pkg::t_state r_state;
    cht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            cht_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = cht_pkg::S_DIV;
                end
            end
            cht_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = cht_pkg::S_HEAD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            // The head RAM read is in flight during this cycle.
            cht_pkg::S_HEAD: n_state = cht_pkg::S_DISP;
            cht_pkg::S_DISP: begin
                o_cmd.rd_free = 1'b1;
                priority if (i_sts.req == cht_pkg::REQ_INSERT) begin
                    n_state = cht_pkg::S_INS;
                end else if (i_sts.req == cht_pkg::REQ_LOOKUP ||
                             i_sts.req == cht_pkg::REQ_DELETE) begin
                    n_state = cht_pkg::S_WALK;
                end else begin
                    n_state = cht_pkg::S_DONE;
                end
            end
            cht_pkg::S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = cht_pkg::S_DONE;
            end
            cht_pkg::S_WALK: begin
                n_state = i_sts.cur_nil ? cht_pkg::S_DONE : cht_pkg::S_CMP;
            end
            cht_pkg::S_CMP: begin
                if (i_sts.key_match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = (i_sts.req == cht_pkg::REQ_DELETE) ? cht_pkg::S_DEL
                                                                   : cht_pkg::S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = cht_pkg::S_WALK;
                end
            end
            cht_pkg::S_DEL: begin
                o_cmd.free_node = 1'b1;
                n_state         = cht_pkg::S_DONE;
            end
            cht_pkg::S_DONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = cht_pkg::S_IDLE;
                end
            end
            default: n_state = cht_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/cht_dp.sv */
// Datapath of the chained hash table: serial modulo, bucket head RAM with
// valid bits, node RAMs, free list and the output register.
// Depends on cht_pkg and cht_ram.
`default_nettype none

module cht_dp #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int NODES   = cht_pkg::NODES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [cht_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  wire logic [cht_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [cht_pkg::KEY_W-1:0]        i_key,
    input  wire logic [cht_pkg::KEY_W-1:0]        i_value,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic      [cht_pkg::ST_W-1:0]         o_status,
    output logic      [cht_pkg::KEY_W-1:0]        o_found,
    input  wire cht_pkg::t_cmd                    i_cmd,
    output cht_pkg::t_sts                         o_sts
);

    localparam int KW = cht_pkg::KEY_W;
    localparam int RW = cht_pkg::REM_W;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    logic [cht_pkg::CFG_W-1:0] r_tsize;
    logic [cht_pkg::REQ_W-1:0] r_req;
    logic [KW-1:0]             r_key;
    logic [KW-1:0]             r_val;
    logic                      r_neg;
    logic [KW-1:0]             r_mag;
    logic [RW-1:0]             r_rem;
    logic [RW-1:0]             r_mod;
    logic [cht_pkg::CNT_W-1:0] r_cnt;
    logic [PW-1:0]             r_cur;
    logic [PW-1:0]             r_prev;
    logic [PW-1:0]             r_free_head;
    logic [PW-1:0]             r_fresh;
    logic [BUCKETS-1:0]        r_hvalid;
    logic [cht_pkg::ST_W-1:0]  r_status;
    logic [KW-1:0]             r_found;
    logic                      r_out_valid;
    logic [cht_pkg::ST_W-1:0]  r_o_status;
    logic [KW-1:0]             r_o_found;

    logic [RW-1:0] w_mod_start;
    logic [RW-1:0] w_trial;
    logic [RW-1:0] w_adj;
    logic [BW-1:0] w_bucket;
    logic [PW-1:0] w_head_rd;
    logic [PW-1:0] w_head;
    logic [KW-1:0] w_key_rd;
    logic [KW-1:0] w_val_rd;
    logic [PW-1:0] w_link_rd;
    logic          w_from_free;
    logic          w_have_node;
    logic [PW-1:0] w_node;
    logic          w_del;
    logic          w_head_we;
    logic [PW-1:0] w_head_wdata;
    logic          w_link_we;
    logic [NW-1:0] w_link_waddr;
    logic [PW-1:0] w_link_wdata;
    logic [NW-1:0] w_link_raddr;
    logic          w_node_we;
    logic          w_slot_free;

    // Zero buckets behaves as one; more than the table holds is clamped.
    always_comb begin
        if (r_tsize == '0) begin
            w_mod_start = RW'(1);
        end else if (int'(r_tsize) > BUCKETS) begin
            w_mod_start = RW'(BUCKETS);
        end else begin
            w_mod_start = RW'(r_tsize);
        end
    end

    assign w_trial = {r_rem[RW-2:0], r_mag[KW-1]};
    // A negative key takes the non-negative remainder.
    assign w_adj    = (r_neg && r_rem != '0) ? (r_mod - r_rem) : r_rem;
    assign w_bucket = BW'(w_adj);

    assign w_head      = r_hvalid[w_bucket] ? w_head_rd : NIL;
    assign w_from_free = (r_free_head != NIL);
    assign w_have_node = w_from_free || (r_fresh != NIL);
    assign w_node      = w_from_free ? r_free_head : r_fresh;
    assign w_del       = (r_req == cht_pkg::REQ_DELETE);
    assign w_node_we   = i_cmd.ins && w_have_node;

    always_comb begin
        w_head_we    = 1'b0;
        w_head_wdata = w_node;
        w_link_we    = 1'b0;
        w_link_waddr = w_node[NW-1:0];
        w_link_wdata = r_cur;
        priority if (w_node_we) begin
            w_head_we = 1'b1;
            w_link_we = 1'b1;
        end else if (i_cmd.hit && w_del) begin
            if (r_prev != NIL) begin
                w_link_we    = 1'b1;
                w_link_waddr = r_prev[NW-1:0];
                w_link_wdata = w_link_rd;
            end else begin
                w_head_we    = 1'b1;
                w_head_wdata = w_link_rd;
            end
        end else if (i_cmd.free_node) begin
            w_link_we    = 1'b1;
            w_link_waddr = r_cur[NW-1:0];
            w_link_wdata = r_free_head;
        end
    end

    assign w_link_raddr = i_cmd.rd_free ? r_free_head[NW-1:0] : r_cur[NW-1:0];

    cht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
        .i_clk  (i_clk),
        .i_we   (w_head_we),
        .i_waddr(w_bucket),
        .i_wdata(w_head_wdata),
        .i_raddr(w_bucket),
        .o_rdata(w_head_rd)
    );

    cht_ram #(.WIDTH(KW), .DEPTH(NODES)) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_node_we),
        .i_waddr(w_node[NW-1:0]),
        .i_wdata(r_key),
        .i_raddr(r_cur[NW-1:0]),
        .o_rdata(w_key_rd)
    );

    cht_ram #(.WIDTH(KW), .DEPTH(NODES)) u_values (
        .i_clk  (i_clk),
        .i_we   (w_node_we),
        .i_waddr(w_node[NW-1:0]),
        .i_wdata(r_val),
        .i_raddr(r_cur[NW-1:0]),
        .o_rdata(w_val_rd)
    );

    cht_ram #(.WIDTH(PW), .DEPTH(NODES)) u_links (
        .i_clk  (i_clk),
        .i_we   (w_link_we),
        .i_waddr(w_link_waddr),
        .i_wdata(w_link_wdata),
        .i_raddr(w_link_raddr),
        .o_rdata(w_link_rd)
    );

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize     <= cht_pkg::TSIZE_RESET;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tsize <= i_cfg_wr_data;
            end
            if (w_head_we) begin
                r_hvalid[w_bucket] <= 1'b1;
            end
            if (w_node_we) begin
                if (w_from_free) begin
                    r_free_head <= w_link_rd;
                end else begin
                    r_fresh <= r_fresh + 1'b1;
                end
            end else if (i_cmd.free_node) begin
                r_free_head <= r_cur;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req_type;
            r_key   <= i_key;
            r_val   <= i_value;
            r_neg   <= i_key[KW-1];
            r_mag   <= i_key[KW-1] ? (~i_key + 1'b1) : i_key;
            r_rem   <= '0;
            r_mod   <= w_mod_start;
            r_cnt   <= '0;
            r_found <= '0;
            r_status <= (i_req_type == cht_pkg::REQ_LOOKUP ||
                         i_req_type == cht_pkg::REQ_DELETE) ? cht_pkg::ST_MISS
                                                            : cht_pkg::ST_OK;
        end
        if (i_cmd.div_step) begin
            r_rem <= (w_trial >= r_mod) ? (w_trial - r_mod) : w_trial;
            r_mag <= {r_mag[KW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.rd_free) begin
            r_cur  <= w_head;
            r_prev <= NIL;
        end
        if (i_cmd.ins && !w_have_node) begin
            r_status <= cht_pkg::ST_FULL;
        end
        if (i_cmd.adv) begin
            r_prev <= r_cur;
            r_cur  <= w_link_rd;
        end
        if (i_cmd.hit) begin
            r_status <= cht_pkg::ST_OK;
            if (!w_del) begin
                r_found <= w_val_rd;
            end
        end
        if (i_cmd.push) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
        end
    end

    assign o_sts.div_done  = (r_cnt == cht_pkg::CNT_W'(cht_pkg::DIV_STEPS));
    assign o_sts.req       = r_req;
    assign o_sts.cur_nil   = (r_cur == NIL);
    assign o_sts.key_match = (w_key_rd == r_key);
    assign o_sts.slot_free = w_slot_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_found     = r_o_found;

endmodule

`default_nettype wire

/* sv/chained_hash_table.sv */
// A request runs the serial modulo and the head read, then an insert or a chain walk that stops at
// a match or at the end of the chain; a delete that matches also returns its node to the free list.
// An unknown request goes straight to the result. Output stalls delay the result hand-off.
// Requests are worked one at a time, the next accepted in the cycle after the result is loaded;
// the 32-step serial modulo and the chain walk through the node RAM read port set this pace.
// Synchronous reset empties all buckets and the pool.
// Top level of the chained hash table; depends on cht_pkg, cht_if, cht_ctrl, cht_dp.
`default_nettype none

module chained_hash_table #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int NODES   = cht_pkg::NODES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [cht_pkg::CFG_W-1:0] i_cfg_wr_data,
    cht_req_if.sink                        i_req,
    cht_rsp_if.source                      o_rsp
);

    cht_pkg::t_cmd w_cmd;
    cht_pkg::t_sts w_sts;
    logic          w_in_ready;

    cht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(w_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    cht_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req_type   (i_req.req_type),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_found      (o_rsp.found_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire

/* sv/cht_checker.sv */
// Port-level checker of the chained hash table and its bind to the top level.
// Depends on assert_macros.svh and cht_pkg.
`default_nettype none
`include "assert_macros.svh"

module cht_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [cht_pkg::ST_W-1:0]  i_status,
    input wire logic [cht_pkg::KEY_W-1:0] i_found
);

    // One request is worked at a time, so a transaction closes the input.
    `CHT_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    `CHT_ASSERT(a_no_bad_status, i_out_valid, i_status != cht_pkg::ST_BAD)

    `CHT_ASSERT(a_found_only_ok, i_out_valid && i_status != cht_pkg::ST_OK, i_found == '0)

    `CHT_ASSERT_NXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_found))

endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_status   (o_rsp.status),
    .i_found    (o_rsp.found_value)
);

`default_nettype wire

/* sim/tb_chained_hash_table.sv */
// Self-checking testbench of the chained hash table: random and directed
// insert, lookup and delete transactions checked against a behavioral table.
// Depends on cht_pkg, cht_if and chained_hash_table.
`timescale 1ns / 1ps

module tb_chained_hash_table;

    localparam int NBKT = 64;
    localparam int NPOOL = 256;
    localparam int NIL = NPOOL;
    localparam logic [cht_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [cht_pkg::REQ_W-1:0]        op;
        logic signed [cht_pkg::KEY_W-1:0] key;
        logic signed [cht_pkg::KEY_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [cht_pkg::ST_W-1:0]         status;
        logic signed [cht_pkg::KEY_W-1:0] found;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [cht_pkg::CFG_W-1:0] i_cfg_wr_data = '0;

    cht_req_if req_ch ();
    cht_rsp_if rsp_ch ();

    chained_hash_table i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req        (req_ch.sink),
        .o_rsp        (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Behavioral copy of the table.
    int unsigned tsize;
    int          heads[NBKT];
    logic [31:0] mkeys[NPOOL];
    logic [31:0] mvals[NPOOL];
    int          links[NPOOL];
    int          fresh;
    int          free_top;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    bit   quiet = 0;        // no idling on either side
    int   hold_cycles = 0;  // long receiver hold-off when set

    function automatic int bucket_of(logic [31:0] k);
        longint m, r;
        m = (tsize == 0) ? 1 : (tsize > NBKT ? NBKT : tsize);
        r = longint'($signed(k)) % m;
        if (r < 0) r += m;
        return int'(r);
    endfunction

    function automatic t_rsp table_apply(t_req r);
        t_rsp o;
        int b, n, prev, steps;
        o = '{status: cht_pkg::ST_OK, found: '0};
        b = bucket_of(r.key);
        case (r.op)
            cht_pkg::REQ_INSERT: begin
                if (free_top != NIL) begin
                    n = free_top;
                    free_top = links[n];
                end else if (fresh < NPOOL) begin
                    n = fresh;
                    fresh++;
                end else begin
                    n = NIL;
                end
                if (n == NIL) begin
                    o.status = cht_pkg::ST_FULL;
                end else begin
                    mkeys[n] = r.key;
                    mvals[n] = r.value;
                    links[n] = heads[b];
                    heads[b] = n;
                end
            end
            cht_pkg::REQ_LOOKUP, cht_pkg::REQ_DELETE: begin
                o.status = cht_pkg::ST_MISS;
                prev = NIL;
                n = heads[b];
                for (steps = 0; n != NIL && steps < NPOOL; steps++) begin
                    if (mkeys[n] == r.key) begin
                        o.status = cht_pkg::ST_OK;
                        if (r.op == cht_pkg::REQ_LOOKUP) begin
                            o.found = mvals[n];
                        end else begin
                            if (prev != NIL) links[prev] = links[n];
                            else heads[b] = links[n];
                            links[n] = free_top;
                            free_top = n;
                        end
                        break;
                    end
                    prev = n;
                    n = links[n];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Driver: offers queued requests with random bursts of idle cycles.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
            end
            if (!req_ch.valid || req_ch.ready) begin
                // Head of the queue is the next item once the current one has gone.
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= pending_reqs[0].op;
                    req_ch.key <= pending_reqs[0].key;
                    req_ch.value <= pending_reqs[0].value;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 8);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls on the response side, checks each transaction.
    int stall = 0;
    t_rsp want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response status=%0d value=%0d", $time,
                             rsp_ch.status, rsp_ch.found_value);
                    errors++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.found_value !== want.found) begin
                        $display("%0t: found_value expected %0d actual %0d", $time,
                                 want.found, rsp_ch.found_value);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                rsp_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall <= stall - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) stall <= $urandom_range(1, 8);
            end
        end
    end

    task automatic queue_req(logic [cht_pkg::REQ_W-1:0] op, logic [31:0] k, logic [31:0] v);
        pending_reqs.push_back('{op: op, key: k, value: v});
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_size(int unsigned sz);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= cht_pkg::CFG_W'(sz);
        tsize = sz & 7'h7f;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Keys mostly from a small set so that lookups and deletes hit.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 20);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 20);
            default: return $signed($urandom_range(0, 80)) - 40;
        endcase
    endfunction

    task automatic random_phase(int count, int ins_bias);
        int r;
        logic [cht_pkg::REQ_W-1:0] op;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < ins_bias) op = cht_pkg::REQ_INSERT;
            else if (r < ins_bias + (100 - ins_bias) / 2) op = cht_pkg::REQ_LOOKUP;
            else if (r < 98) op = cht_pkg::REQ_DELETE;
            else op = REQ_UNKNOWN;
            queue_req(op, pick_key(), $urandom());
        end
    endtask

    initial begin
        tsize = 64;
        fresh = 0;
        free_top = NIL;
        foreach (heads[i]) heads[i] = NIL;
        foreach (links[i]) links[i] = NIL;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.key = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, duplicates, chain deletes, unknown request.
        queue_req(cht_pkg::REQ_LOOKUP, 32'd5, 32'd0);
        queue_req(cht_pkg::REQ_DELETE, 32'd5, 32'd0);
        queue_req(cht_pkg::REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(cht_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(cht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(cht_pkg::REQ_INSERT, 32'd63, 32'd1);
        queue_req(cht_pkg::REQ_INSERT, 32'd63, 32'd2);
        queue_req(cht_pkg::REQ_INSERT, 32'd127, 32'd3);
        queue_req(cht_pkg::REQ_LOOKUP, 32'd63, 32'd0);
        queue_req(cht_pkg::REQ_LOOKUP, 32'h8000_0000, 32'd0);
        queue_req(cht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        queue_req(cht_pkg::REQ_DELETE, 32'd63, 32'd0);
        queue_req(cht_pkg::REQ_LOOKUP, 32'd63, 32'd0);
        queue_req(cht_pkg::REQ_DELETE, 32'd127, 32'd0);
        queue_req(cht_pkg::REQ_DELETE, 32'd63, 32'd0);
        queue_req(cht_pkg::REQ_LOOKUP, 32'd63, 32'd0);
        queue_req(REQ_UNKNOWN, 32'd1, 32'd1);
        queue_req(cht_pkg::REQ_INSERT, 32'd0, 32'h0000_0000);
        queue_req(cht_pkg::REQ_LOOKUP, 32'd0, 32'd0);
        drain();

        // Size 1: a single long chain.
        write_size(1);
        random_phase(150, 50);
        drain();

        // Fill the pool to exhaustion with a long receiver hold-off.
        write_size(0);
        hold_cycles = 400;
        random_phase(300, 95);
        drain();

        // Size above the bucket count.
        write_size(127);
        random_phase(250, 30);
        drain();

        write_size(7);
        random_phase(250, 40);
        drain();

        write_size(64);
        random_phase(250, 40);
        drain();

        // Last part without idling.
        quiet = 1;
        write_size(33);
        random_phase(200, 40);
        drain();

        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Worst case: ~1400 items, chains up to 256 nodes, about 3.3 ms.
    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
